FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the command frame parser RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Check that an expression holds at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed");
// Check that a condition implies a consequence in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Check that a condition implies a consequence in the following cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: hw/rtl/xcfp_pkg.sv
// Shared types, constants and helpers of the command frame parser.
package xcfp_pkg;

	localparam int MaxBody = 256;
	localparam int CntW    = $clog2(MaxBody + 1);

	localparam logic [7:0] ChStart = 8'h24;
	localparam logic [7:0] ChStar  = 8'h2A;
	localparam logic [7:0] ChEnd   = 8'h0A;

	localparam logic [39:0] NamePsign = "PSIGN";
	localparam logic [39:0] NamePflsh = "PFLSH";
	localparam logic [39:0] NamePblfl = "PBLFL";
	localparam logic [39:0] NamePeepr = "PEEPR";

	localparam logic [8:0] PlenMax = 9'd511;

	typedef enum logic [1:0] {
		VERDICT_VALID    = 2'd0,
		VERDICT_MISMATCH = 2'd1,
		VERDICT_OVERFLOW = 2'd2
	} verdict_t;

	typedef enum logic [2:0] {
		CMD_NONE  = 3'd0,
		CMD_PSIGN = 3'd1,
		CMD_PFLSH = 3'd2,
		CMD_PBLFL = 3'd3,
		CMD_PEEPR = 3'd4
	} cmd_kind_t;

	typedef struct packed {
		logic [CntW-1:0] body_count;
		logic [7:0]      running_xor;
		logic            star_seen;
		logic [CntW-1:0] star_pos;
		logic [1:0]      digits;
		logic [15:0]     chk_chars;
		logic [39:0]     name;
		logic            overflowed;
	} frame_t;

	typedef struct packed {
		verdict_t    verdict;
		cmd_kind_t   command_kind;
		logic [8:0]  payload_length;
		logic [7:0]  computed_checksum;
	} result_t;

	// Uppercase ASCII hex digit of a nibble.
	function automatic logic [7:0] hex_upper(input logic [3:0] nib);
		logic [7:0] wide;
		wide = {4'd0, nib};
		if (nib < 4'd10) begin
			return 8'h30 + wide;
		end
		return 8'h37 + wide;
	endfunction

endpackage

FILE: hw/rtl/xcfp_byte_if.sv
// Word channel carrying one received byte.
interface xcfp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

FILE: hw/rtl/xcfp_result_if.sv
// Word channel carrying one frame verdict.
interface xcfp_result_if;
	logic       valid;
	logic       ready;
	logic [1:0] verdict;
	logic [2:0] command_kind;
	logic [8:0] payload_length;
	logic [7:0] computed_checksum;

	modport source (output valid, output verdict, output command_kind,
		output payload_length, output computed_checksum, input ready);
	modport sink (input valid, input verdict, input command_kind,
		input payload_length, input computed_checksum, output ready);
endinterface

FILE: hw/rtl/xor_checksum_command_frame_parser.sv
// XOR-checksummed command frame parser, top level.
// Usage: bytes of the serial command stream enter on rx, one word per
// accepted handshake. A '$' opens a frame, a newline closes it; a closed
// frame that carried a '*' or overran the body limit yields one verdict word
// on res (verdict, command_kind, payload_length, computed_checksum).
// Other bytes give no word on res.
// Path: an accepted byte is held in the input register; the verdict word of a
// closing newline is loaded from there into the result register, which
// drives res.valid and the word until the receiver takes it.
// Throughput: one byte per cycle while no closing newline waits on a held
// res word, set by the combinational frame update after the input register.
// Stall: while res is held by the receiver, bytes that yield no verdict keep
// flowing; a closing newline waits in the input register until the pending
// word is taken, and rx.ready stays low while it waits.
// Reset: arst_n clears the open frame and empties both registers; the block
// takes bytes as soon as reset is released.
`include "assert_macros.svh"
module xor_checksum_command_frame_parser (
	input  logic                 clk,
	input  logic                 arst_n,
	xcfp_byte_if.sink            rx,
	xcfp_result_if.source        res
);

	logic              byte_valid_s1;
	logic [7:0]        byte_s1;
	logic              advance;
	logic              close;
	xcfp_pkg::frame_t  frame;
	xcfp_pkg::result_t result;
	logic              res_valid_q;
	xcfp_pkg::result_t res_q;

	xcfp_frame_state u_state (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.rx_byte (byte_s1),
		.close   (close),
		.frame   (frame)
	);

	xcfp_verdict u_verdict (
		.frame  (frame),
		.result (result)
	);

	// Consume the held byte unless its verdict has nowhere to go
	assign advance  = byte_valid_s1 && (!close || !res_valid_q || res.ready);
	assign rx.ready = !byte_valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid_s1 <= 1'b0;
			byte_s1       <= 8'd0;
		end else if (rx.ready) begin
			byte_valid_s1 <= rx.valid;
			byte_s1       <= rx.rx_byte;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else if (advance && close) begin
			res_valid_q <= 1'b1;
			res_q       <= result;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	assign res.valid             = res_valid_q;
	assign res.verdict           = res_q.verdict;
	assign res.command_kind      = res_q.command_kind;
	assign res.payload_length    = res_q.payload_length;
	assign res.computed_checksum = res_q.computed_checksum;

	`ASSERT_NEXT(a_hold_stalled_byte, clk, arst_n, byte_valid_s1 && !advance,
		byte_valid_s1 && $stable(byte_s1))
	`ASSERT_IMPLIES(a_kind_only_when_valid, clk, arst_n,
		res_valid_q && res_q.command_kind != xcfp_pkg::CMD_NONE,
		res_q.verdict == xcfp_pkg::VERDICT_VALID)
	`ASSERT_IMPLIES(a_overflow_zeroed, clk, arst_n,
		res_valid_q && res_q.verdict == xcfp_pkg::VERDICT_OVERFLOW,
		res_q.payload_length == 9'd0 && res_q.computed_checksum == 8'd0)
	`ASSERT_NEXT(a_load_sets_valid, clk, arst_n, advance && close, res_valid_q)

endmodule

FILE: hw/rtl/xcfp_frame_state.sv
// Frame tracker: open/close detection, running XOR, star, checksum digit and name capture, overflow.
`include "assert_macros.svh"
module xcfp_frame_state (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          rx_byte,
	output logic                close,
	output xcfp_pkg::frame_t    frame
);

	localparam int CW = xcfp_pkg::CntW;

	logic             in_frame_q;
	xcfp_pkg::frame_t frame_q;
	logic             in_frame_d;
	xcfp_pkg::frame_t frame_d;
	logic [CW-1:0]    pos;
	logic [2:0]       slot;
	logic [39:0]      name_or;

	assign frame = frame_q;
	assign pos   = frame_q.body_count;
	assign slot  = 3'd4 - pos[2:0];

	// Flag a closing newline that yields a verdict
	assign close = in_frame_q && (rx_byte == xcfp_pkg::ChEnd)
		&& (frame_q.overflowed || frame_q.star_seen);

	// Next frame state for the byte in hand
	always_comb begin
		in_frame_d = in_frame_q;
		frame_d    = frame_q;
		name_or    = 40'(rx_byte) << {slot, 3'b000};
		if (rx_byte == xcfp_pkg::ChStart) begin
			in_frame_d = 1'b1;
			frame_d    = '0;
		end else if (in_frame_q) begin
			if (rx_byte == xcfp_pkg::ChEnd) begin
				in_frame_d = 1'b0;
			end else if (pos >= CW'(xcfp_pkg::MaxBody)) begin
				frame_d.overflowed = 1'b1;
			end else begin
				frame_d.body_count = pos + CW'(1);
				if (!frame_q.star_seen) begin
					if (rx_byte == xcfp_pkg::ChStar) begin
						frame_d.star_seen = 1'b1;
						frame_d.star_pos  = pos;
					end else begin
						frame_d.running_xor = frame_q.running_xor ^ rx_byte;
					end
				end else if (frame_q.digits < 2'd2) begin
					frame_d.chk_chars = {frame_q.chk_chars[7:0], rx_byte};
					frame_d.digits    = frame_q.digits + 2'd1;
				end
				if (pos < CW'(5)) begin
					frame_d.name = frame_q.name | name_or;
				end
			end
		end
	end

	// Advance on each consumed byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			frame_q    <= '0;
		end else if (step) begin
			in_frame_q <= in_frame_d;
			frame_q    <= frame_d;
		end
	end

	`ASSERT_IMPLIES(a_ovf_full, clk, arst_n, frame_q.overflowed,
		frame_q.body_count == CW'(xcfp_pkg::MaxBody))
	`ASSERT_ALWAYS(a_digits_range, clk, arst_n, frame_q.digits != 2'd3)
	`ASSERT_IMPLIES(a_no_digits_before_star, clk, arst_n, !frame_q.star_seen,
		frame_q.digits == 2'd0 && frame_q.chk_chars == 16'd0)
	`ASSERT_IMPLIES(a_star_in_body, clk, arst_n, frame_q.star_seen,
		frame_q.star_pos < frame_q.body_count)

endmodule

FILE: hw/rtl/xcfp_verdict.sv
// Verdict logic: checksum compare, command match and payload length.
module xcfp_verdict (
	input  xcfp_pkg::frame_t  frame,
	output xcfp_pkg::result_t result
);

	localparam int CW = xcfp_pkg::CntW;

	logic [15:0]         expect_chars;
	logic                good;
	logic [CW-1:0]       diff;
	logic [8:0]          plen;
	xcfp_pkg::cmd_kind_t kind;

	assign expect_chars = {xcfp_pkg::hex_upper(frame.running_xor[7:4]),
		xcfp_pkg::hex_upper(frame.running_xor[3:0])};
	assign good = (frame.digits == 2'd2) && (frame.chk_chars == expect_chars);
	assign diff = frame.star_pos - CW'(5);

	// Saturate the payload length
	always_comb begin
		if (frame.star_pos < CW'(5)) begin
			plen = 9'd0;
		end else if ({1'b0, diff} > (CW + 1)'(xcfp_pkg::PlenMax)) begin
			plen = xcfp_pkg::PlenMax;
		end else begin
			plen = 9'(diff);
		end
	end

	// Match the command name
	always_comb begin
		kind = xcfp_pkg::CMD_NONE;
		if (good && frame.body_count >= CW'(5)) begin
			priority if (frame.name == xcfp_pkg::NamePsign) begin
				kind = xcfp_pkg::CMD_PSIGN;
			end else if (frame.name == xcfp_pkg::NamePflsh) begin
				kind = xcfp_pkg::CMD_PFLSH;
			end else if (frame.name == xcfp_pkg::NamePblfl) begin
				kind = xcfp_pkg::CMD_PBLFL;
			end else if (frame.name == xcfp_pkg::NamePeepr) begin
				kind = xcfp_pkg::CMD_PEEPR;
			end else begin
				kind = xcfp_pkg::CMD_NONE;
			end
		end
	end

	// Pick the verdict word
	always_comb begin
		if (frame.overflowed) begin
			result.verdict           = xcfp_pkg::VERDICT_OVERFLOW;
			result.command_kind      = xcfp_pkg::CMD_NONE;
			result.payload_length    = 9'd0;
			result.computed_checksum = 8'd0;
		end else begin
			result.verdict           = good ? xcfp_pkg::VERDICT_VALID
				: xcfp_pkg::VERDICT_MISMATCH;
			result.command_kind      = kind;
			result.payload_length    = plen;
			result.computed_checksum = frame.running_xor;
		end
	end

endmodule
